// ===== sv/agov_pkg.sv =====
// Shared types, constants and helper functions of the bitrate governor.
package agov_pkg;

    localparam int NUM_SESSIONS = 8;
    localparam int SES_W        = 3;
    localparam int RATE_W       = 20;
    localparam int DROP_W       = 32;
    localparam int PCT_W        = 7;
    localparam int LIMIT_W      = 16;
    localparam int STEP_W       = 16;
    localparam int COUNT_W      = 8;
    localparam int HEALTH_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int PROD_W       = RATE_W + PCT_W;

    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] RST_DROP_LIMIT = 16'd5;
    localparam logic [PCT_W-1:0]   RST_CUT_PCT    = 7'd20;
    localparam logic [PCT_W-1:0]   RST_FLOOR_PCT  = 7'd40;
    localparam logic [STEP_W-1:0]  RST_STEP_UP    = 16'd300;
    localparam logic [COUNT_W-1:0] RST_COOLDOWN   = 8'd5;

    // Division by 100 through a reciprocal: exact for every dividend below 2^30.
    localparam int                DIV100_SHIFT = 33;
    localparam logic [PROD_W-1:0] DIV100_MAG   = 27'd85899346;

    // Queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [HEALTH_W-1:0] HEALTH_OK        = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_CONGESTED = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_DOWN = 2'd1,
        ACT_UP   = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_LIMIT = 3'd0,
        CFG_CUT_PCT    = 3'd1,
        CFG_FLOOR_PCT  = 3'd2,
        CFG_STEP_UP    = 3'd3,
        CFG_COOLDOWN   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [LIMIT_W-1:0] drop_burst_limit;
        logic [PCT_W-1:0]   cut_percent;
        logic [PCT_W-1:0]   floor_percent;
        logic [STEP_W-1:0]  step_up_kbps;
        logic [COUNT_W-1:0] cooldown_ticks;
    } t_cfg;

    // A classified tick as it waits in the queue.
    typedef struct packed {
        logic [SES_W-1:0]  session_index;
        logic              out_of_range;
        logic              active;
        logic              congested;
        logic              healthy;
        logic [DROP_W-1:0] dropped_total;
        logic [RATE_W-1:0] profile_kbps;
        logic [RATE_W-1:0] floor_rate;
    } t_tick;

    function automatic logic [PCT_W-1:0] pct_sat(input logic [PCT_W-1:0] p);
        return (p > PCT_MAX) ? PCT_MAX : p;
    endfunction

    function automatic logic [RATE_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [2*PROD_W-1:0] p;
        p = {{PROD_W{1'b0}}, x} * {{PROD_W{1'b0}}, DIV100_MAG};
        return p[DIV100_SHIFT+RATE_W-1:DIV100_SHIFT];
    endfunction

endpackage

// ===== sv/agov_tick_if.sv =====
// Handshake interface carrying one health tick.
interface agov_tick_if;
    import agov_pkg::*;

    logic                valid;
    logic                ready;
    logic [SES_W-1:0]    session_index;
    logic                session_active;
    logic [HEALTH_W-1:0] health_code;
    logic [DROP_W-1:0]   dropped_total;
    logic [RATE_W-1:0]   profile_kbps;

    modport source (
        output valid, session_index, session_active, health_code, dropped_total,
               profile_kbps,
        input  ready
    );
    modport sink (
        input  valid, session_index, session_active, health_code, dropped_total,
               profile_kbps,
        output ready
    );
endinterface

// ===== sv/agov_result_if.sv =====
// Handshake interface carrying one governor result.
interface agov_result_if;
    import agov_pkg::*;

    logic              valid;
    logic              ready;
    logic [SES_W-1:0]  tick_session;
    logic [1:0]        rate_action;
    logic [RATE_W-1:0] rate_kbps;

    modport source (
        output valid, tick_session, rate_action, rate_kbps,
        input  ready
    );
    modport sink (
        input  valid, tick_session, rate_action, rate_kbps,
        output ready
    );
endinterface

// ===== sv/agov_front.sv =====
// Front end: accepts ticks, classifies them and works out the floor rate.
module agov_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    agov_tick_if.sink       i_tick,
    input  agov_pkg::t_cfg  i_cfg,
    input  logic            i_q_full,
    output logic            o_push,
    output agov_pkg::t_tick o_push_data
);
    import agov_pkg::*;

    logic              r_f_valid;
    t_tick             r_f;
    logic [PROD_W-1:0] r_f_prod;
    t_tick             n_f;
    logic [PROD_W-1:0] n_f_prod;
    logic              take;

    assign o_push         = r_f_valid && !i_q_full;
    assign i_tick.ready   = !r_f_valid || !i_q_full;
    assign take           = i_tick.valid && i_tick.ready;

    always_comb begin
        n_f               = '0;
        n_f.session_index = i_tick.session_index;
        n_f.out_of_range  = int'(i_tick.session_index) >= NUM_SESSIONS;
        n_f.active        = i_tick.session_active;
        n_f.congested     = i_tick.health_code == HEALTH_CONGESTED;
        n_f.healthy       = i_tick.health_code == HEALTH_OK;
        n_f.dropped_total = i_tick.dropped_total;
        n_f.profile_kbps  = i_tick.profile_kbps;
        n_f_prod = {{PCT_W{1'b0}}, i_tick.profile_kbps}
                 * {{RATE_W{1'b0}}, pct_sat(i_cfg.floor_percent)};
    end

    always_comb begin
        o_push_data            = r_f;
        o_push_data.floor_rate = div100(r_f_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (take) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_f      <= n_f;
            r_f_prod <= n_f_prod;
        end
    end

endmodule

// ===== sv/agov_queue.sv =====
// Two-entry queue of classified ticks between front and back.
module agov_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  agov_pkg::t_tick i_push_data,
    output logic            o_full,
    output logic            o_valid,
    output agov_pkg::t_tick o_head,
    input  logic            i_pop
);
    import agov_pkg::*;

    t_tick              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

// ===== sv/agov_back.sv =====
// Back end: session table read-modify-write and the result register.
module agov_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  agov_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  agov_pkg::t_tick i_q_head,
    output logic            o_pop,
    agov_result_if.source   o_result
);
    import agov_pkg::*;

    typedef struct packed {
        t_tick              tick;
        logic [RATE_W-1:0]  rate0;
        logic [COUNT_W-1:0] clean;
        logic               burst;
        logic               delta_zero;
        logic [PROD_W-1:0]  cut_prod;
    } t_exec;

    // Session table.
    logic [RATE_W-1:0]  r_rate  [NUM_SESSIONS];
    logic [DROP_W-1:0]  r_last  [NUM_SESSIONS];
    logic [COUNT_W-1:0] r_clean [NUM_SESSIONS];

    t_back_state r_state, n_state;
    t_exec       r_x, n_x;

    logic               r_out_valid;
    logic [SES_W-1:0]   r_out_session;
    t_action            r_out_action;
    logic [RATE_W-1:0]  r_out_rate;

    logic               fire;
    logic               wr_en;
    logic [RATE_W-1:0]  n_rate;
    logic [COUNT_W-1:0] n_clean;
    t_action            n_action;
    logic [RATE_W-1:0]  n_out_rate;

    // Read stage: look up the session and form the cut product.
    always_comb begin
        logic [RATE_W-1:0] gr;
        logic [DROP_W-1:0] last_eff;
        logic [DROP_W-1:0] delta;
        logic              first;
        gr         = r_rate[i_q_head.session_index];
        first      = gr == '0;
        last_eff   = first ? i_q_head.dropped_total : r_last[i_q_head.session_index];
        delta      = i_q_head.dropped_total - last_eff;
        n_x.tick   = i_q_head;
        n_x.rate0  = (first && i_q_head.active) ? i_q_head.profile_kbps : gr;
        n_x.clean  = r_clean[i_q_head.session_index];
        n_x.burst  = delta > {{(DROP_W-LIMIT_W){1'b0}}, i_cfg.drop_burst_limit};
        n_x.delta_zero = delta == '0;
        n_x.cut_prod = {{PCT_W{1'b0}}, n_x.rate0}
                     * {{RATE_W{1'b0}}, pct_sat(i_cfg.cut_percent)};
    end

    // Execute stage: decide the action and the new rate.
    always_comb begin
        logic [RATE_W-1:0]  cut_rate;
        logic [COUNT_W-1:0] cnt;
        logic [RATE_W:0]    sum;
        n_rate   = r_x.rate0;
        n_clean  = '0;
        n_action = ACT_NONE;
        cut_rate = r_x.rate0 - div100(r_x.cut_prod);
        cnt      = (r_x.clean == COUNT_MAX) ? COUNT_MAX : r_x.clean + COUNT_W'(1);
        sum      = {1'b0, r_x.rate0} + {{(RATE_W+1-STEP_W){1'b0}}, i_cfg.step_up_kbps};
        if (r_x.tick.congested || r_x.burst) begin
            if (r_x.rate0 > r_x.tick.floor_rate) begin
                n_rate   = (cut_rate < r_x.tick.floor_rate) ? r_x.tick.floor_rate
                                                            : cut_rate;
                n_action = ACT_DOWN;
            end
        end else if (r_x.tick.healthy && r_x.delta_zero
                     && r_x.rate0 < r_x.tick.profile_kbps) begin
            if (cnt >= i_cfg.cooldown_ticks) begin
                n_rate   = (sum > {1'b0, r_x.tick.profile_kbps}) ? r_x.tick.profile_kbps
                                                                 : sum[RATE_W-1:0];
                n_action = ACT_UP;
            end else begin
                n_clean = cnt;
            end
        end

        if (r_x.tick.out_of_range) begin
            n_out_rate = '0;
        end else if (!r_x.tick.active) begin
            n_out_rate = r_x.rate0;
        end else begin
            n_out_rate = n_rate;
        end
    end

    // Sequencer: table read when idle, execute and write-back once output is free.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        fire    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!r_out_valid || o_result.ready) begin
                    fire    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign wr_en = fire && r_x.tick.active && !r_x.tick.out_of_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_x <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SESSIONS; i++) begin
                r_rate[i]  <= '0;
                r_last[i]  <= '0;
                r_clean[i] <= '0;
            end
        end else if (wr_en) begin
            r_rate[r_x.tick.session_index]  <= n_rate;
            r_last[r_x.tick.session_index]  <= r_x.tick.dropped_total;
            r_clean[r_x.tick.session_index] <= n_clean;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_session <= r_x.tick.session_index;
            r_out_action  <= (r_x.tick.active && !r_x.tick.out_of_range) ? n_action
                                                                          : ACT_NONE;
            r_out_rate    <= n_out_rate;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.tick_session = r_out_session;
    assign o_result.rate_action  = r_out_action;
    assign o_result.rate_kbps    = r_out_rate;

    a_down_within_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_action == ACT_DOWN)
        |-> (n_rate >= r_x.tick.floor_rate) && (n_rate <= r_x.rate0))
        else $error("down-step left the band between floor and old rate");

    a_up_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_action == ACT_UP)
        |-> (n_rate <= r_x.tick.profile_kbps) && (n_rate >= r_x.rate0))
        else $error("up-step exceeded the profile rate");

endmodule

// ===== sv/aimd_bitrate_governor.sv =====
// Top level of the AIMD bitrate governor: configuration registers and the three stages.
//
//  Channel    Direction  Handshake          Word
//  i_tick     in         valid / ready      one health tick for one session
//  o_result   out        valid / ready      tick_session, rate_action, rate_kbps
//  i_cfg_*    in         write enable only  register index and data
//
//  The back end takes each word through a table read, then execute and write-back,
//  and pops no new word until the last one is through. A result passes the front
//  register, the queue, the back end's stage register and the result register.
//  Reset is synchronous and active low; it clears the session table and loads the
//  register defaults. The front end keeps accepting while the back end works or
//  a result waits, until its stage and the two-entry queue are full.
module aimd_bitrate_governor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    agov_tick_if.sink                          i_tick,
    agov_result_if.source                      o_result,
    input  logic                               i_cfg_we,
    input  logic [agov_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [agov_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import agov_pkg::*;

    // Configuration registers. Writes to indices beyond the list are dropped.
    t_cfg r_cfg;

    // Front to queue, queue to back.
    logic  push;
    t_tick push_data;
    logic  q_full;
    logic  q_valid;
    t_tick q_head;
    logic  pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drop_burst_limit <= RST_DROP_LIMIT;
            r_cfg.cut_percent      <= RST_CUT_PCT;
            r_cfg.floor_percent    <= RST_FLOOR_PCT;
            r_cfg.step_up_kbps     <= RST_STEP_UP;
            r_cfg.cooldown_ticks   <= RST_COOLDOWN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DROP_LIMIT: r_cfg.drop_burst_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_CUT_PCT:    r_cfg.cut_percent      <= i_cfg_data[PCT_W-1:0];
                CFG_FLOOR_PCT:  r_cfg.floor_percent    <= i_cfg_data[PCT_W-1:0];
                CFG_STEP_UP:    r_cfg.step_up_kbps     <= i_cfg_data[STEP_W-1:0];
                CFG_COOLDOWN:   r_cfg.cooldown_ticks   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The front end classifies each word and works out the floor rate from the
    // profile, so that the back end only has the cut left to compute.
    agov_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (i_tick),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    agov_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (pop)
    );

    // The back end handles one word at a time, so a word always sees the table
    // as the previous word left it.
    agov_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_result  (o_result)
    );

endmodule

// ===== bench/tb_aimd_bitrate_governor.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the AIMD bitrate governor: random and directed health ticks.
module tb_aimd_bitrate_governor;
    import agov_pkg::*;

    // A health tick as it is handed to the block, and the rate word that comes back.
    typedef struct packed {
        logic [SES_W-1:0]    session;
        logic                active;
        logic [HEALTH_W-1:0] health;
        logic [DROP_W-1:0]   drops;
        logic [RATE_W-1:0]   profile;
    } tick_word_t;

    typedef struct packed {
        logic [SES_W-1:0]  session;
        t_action           action;
        logic [RATE_W-1:0] rate;
    } rate_word_t;

    // Words per random phase, the settling time after the last result, the length
    // of the long receiver hold-off and the number of cycles without any handshake
    // that ends the run.
    localparam int PHASE_WORDS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int SETTLE_TICKS = 8;
    localparam int HOLD_TICKS   = 300;
    localparam int QUIET_LIMIT  = 3000;

    // The scoreboard keeps its own copy of the session table and the registers,
    // works out the rate word for every accepted tick and compares the block's
    // answers, in order, against those predictions.
    class rate_scoreboard;
        logic [LIMIT_W-1:0] burst_limit;
        logic [PCT_W-1:0]   cut_pct;
        logic [PCT_W-1:0]   floor_pct;
        logic [STEP_W-1:0]  step_kbps;
        logic [COUNT_W-1:0] cooldown;
        logic [RATE_W-1:0]  rate_tab  [NUM_SESSIONS];
        logic [DROP_W-1:0]  drops_tab [NUM_SESSIONS];
        logic [COUNT_W-1:0] clean_tab [NUM_SESSIONS];
        rate_word_t         expected_rates [$];
        int                 failures;

        function new();
            burst_limit = RST_DROP_LIMIT;
            cut_pct     = RST_CUT_PCT;
            floor_pct   = RST_FLOOR_PCT;
            step_kbps   = RST_STEP_UP;
            cooldown    = RST_COOLDOWN;
            failures    = 0;
            for (int i = 0; i < NUM_SESSIONS; i++) begin
                rate_tab[i]  = '0;
                drops_tab[i] = '0;
                clean_tab[i] = '0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DROP_LIMIT: burst_limit = data[LIMIT_W-1:0];
                CFG_CUT_PCT:    cut_pct     = data[PCT_W-1:0];
                CFG_FLOOR_PCT:  floor_pct   = data[PCT_W-1:0];
                CFG_STEP_UP:    step_kbps   = data[STEP_W-1:0];
                CFG_COOLDOWN:   cooldown    = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Percentages above one hundred count as one hundred.
        function longint unsigned percent_of(longint unsigned value, logic [PCT_W-1:0] pct);
            longint unsigned p;
            p = (pct > PCT_MAX) ? PCT_MAX : pct;
            return value * p / 100;
        endfunction

        function void note_tick(tick_word_t w);
            rate_word_t        r;
            int unsigned       s;
            longint unsigned   rate;
            longint unsigned   floor_rate;
            logic [DROP_W-1:0] delta;
            s         = w.session;
            r.session = w.session;
            r.action  = ACT_NONE;
            if (s >= NUM_SESSIONS) begin
                r.rate = '0;
            end else if (!w.active) begin
                r.rate = rate_tab[s];
            end else begin
                // A zero rate marks a session not yet seen: load the profile and
                // take the drop counter as the new baseline.
                if (rate_tab[s] == '0) begin
                    rate_tab[s]  = w.profile;
                    drops_tab[s] = w.drops;
                end
                rate         = rate_tab[s];
                delta        = w.drops - drops_tab[s];
                drops_tab[s] = w.drops;
                if (w.health == HEALTH_CONGESTED || delta > burst_limit) begin
                    floor_rate   = percent_of(w.profile, floor_pct);
                    clean_tab[s] = '0;
                    if (rate > floor_rate) begin
                        rate = rate - percent_of(rate, cut_pct);
                        if (rate < floor_rate)
                            rate = floor_rate;
                        r.action = ACT_DOWN;
                    end
                end else if (w.health == HEALTH_OK && delta == '0 && rate < w.profile) begin
                    if (clean_tab[s] != COUNT_MAX)
                        clean_tab[s]++;
                    if (clean_tab[s] >= cooldown) begin
                        clean_tab[s] = '0;
                        rate = rate + step_kbps;
                        if (rate > w.profile)
                            rate = w.profile;
                        r.action = ACT_UP;
                    end
                end else begin
                    clean_tab[s] = '0;
                end
                rate_tab[s] = RATE_W'(rate);
                r.rate      = rate_tab[s];
            end
            expected_rates.push_back(r);
        endfunction

        function void check_result(rate_word_t got);
            rate_word_t want;
            if (expected_rates.size() == 0) begin
                failures++;
                $display("%0t: rate word with none expected: session %0d action %0d rate %0d",
                         $time, got.session, got.action, got.rate);
                return;
            end
            want = expected_rates.pop_front();
            if (got.session !== want.session) begin
                failures++;
                $display("%0t: tick_session expected %0d, actual %0d",
                         $time, want.session, got.session);
            end
            if (got.action !== want.action) begin
                failures++;
                $display("%0t: rate_action expected %0d, actual %0d",
                         $time, want.action, got.action);
            end
            if (got.rate !== want.rate) begin
                failures++;
                $display("%0t: rate_kbps expected %0d, actual %0d",
                         $time, want.rate, got.rate);
            end
        endfunction

        function int pending();
            return expected_rates.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    agov_tick_if   tick_bus ();
    agov_result_if result_bus ();

    aimd_bitrate_governor dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_tick   (tick_bus),
        .o_result (result_bus),
        .i_cfg_we (cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    rate_scoreboard    board;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    bit                hold_request   = 1'b0;
    int                quiet_cycles   = 0;

    // Per-session stimulus state: the drop counter and profile the sender keeps
    // presenting, so that most ticks form clean runs that reach the up-steps.
    logic [DROP_W-1:0] gen_drops   [NUM_SESSIONS];
    logic [RATE_W-1:0] gen_profile [NUM_SESSIONS];

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before any register of the
    // block updates, so every word is seen with the values that were accepted.
    always @(posedge clk) begin : monitor
        tick_word_t seen_tick;
        rate_word_t seen_rate;
        if (rst_n) begin
            if (tick_bus.valid && tick_bus.ready) begin
                seen_tick = '{session: tick_bus.session_index,
                              active:  tick_bus.session_active,
                              health:  tick_bus.health_code,
                              drops:   tick_bus.dropped_total,
                              profile: tick_bus.profile_kbps};
                board.note_tick(seen_tick);
            end
            if (result_bus.valid && result_bus.ready) begin
                seen_rate = '{session: result_bus.tick_session,
                              action:  t_action'(result_bus.rate_action),
                              rate:    result_bus.rate_kbps};
                board.check_result(seen_rate);
            end
        end
    end

    // The run is abandoned once no word has moved on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (tick_bus.valid && tick_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("aimd_bitrate_governor: mismatch");
                $finish;
            end
        end
    end

    // Receiver: stalls at random, and on request holds off for a long stretch so
    // that the block fills up and has to refuse further ticks.
    initial begin
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_TICKS) begin
                    result_bus.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one tick, with random idle cycles ahead of it, and returns at the
    // edge where it is accepted. Valid is left high so that back-to-back words
    // need no second assignment in the same step.
    task automatic send_tick(input logic [SES_W-1:0] s, input logic act,
                             input logic [HEALTH_W-1:0] h, input logic [DROP_W-1:0] d,
                             input logic [RATE_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            tick_bus.valid <= 1'b0;
            @(posedge clk);
        end
        tick_bus.valid          <= 1'b1;
        tick_bus.session_index  <= s;
        tick_bus.session_active <= act;
        tick_bus.health_code    <= h;
        tick_bus.dropped_total  <= d;
        tick_bus.profile_kbps   <= p;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
    endtask

    // Stops offering and waits until every predicted word has come back, then
    // lets the pipeline settle so the block is truly idle.
    task automatic wait_for_results();
        tick_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Writes all five registers back to back; the enable drops after the last one.
    task automatic program_governor(input logic [15:0] limit, input logic [15:0] cut,
                                    input logic [15:0] floor_p, input logic [15:0] step,
                                    input logic [15:0] cool);
        write_reg(CFG_DROP_LIMIT, limit);
        write_reg(CFG_CUT_PCT, cut);
        write_reg(CFG_FLOOR_PCT, floor_p);
        write_reg(CFG_STEP_UP, step);
        write_reg(CFG_COOLDOWN, cool);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly modest profiles, with the full range and the occasional zero.
    function automatic logic [RATE_W-1:0] random_profile();
        case ($urandom_range(7))
            0:       return '0;
            1, 2:    return RATE_W'($urandom_range((1 << RATE_W) - 1));
            default: return RATE_W'($urandom_range(5000, 200));
        endcase
    endfunction

    // Three ticks in four are clean healthy ticks on a steady profile; the rest
    // carry random health, activity, drop jumps, counter wraps or a new profile.
    task automatic send_random_tick();
        int unsigned         s;
        logic                act;
        logic [HEALTH_W-1:0] h;
        s   = $urandom_range(1) ? $urandom_range(1) : $urandom_range(NUM_SESSIONS - 1);
        act = 1'b1;
        h   = HEALTH_OK;
        if ($urandom_range(99) >= 75) begin
            act = ($urandom_range(9) != 0);
            h   = HEALTH_W'($urandom_range(3));
            case ($urandom_range(3))
                0:       gen_drops[s] = gen_drops[s] + $urandom_range(12, 1);
                1:       gen_drops[s] = $urandom;
                2:       gen_profile[s] = random_profile();
                default: ;
            endcase
        end
        send_tick(SES_W'(s), act, h, gen_drops[s], gen_profile[s]);
    endtask

    // Directed ticks under the reset register values: first loads, cuts down to
    // the floor and a cut held at the floor, a full cooldown run ending in an
    // up-step, the warning code and the unused code, a drop burst against a drop
    // just at the limit, inactive ticks, a zero profile, counter wrap and the
    // widest profile.
    task automatic run_directed();
        send_tick(0, 1'b1, HEALTH_OK, 100, 1000);
        repeat (6) send_tick(0, 1'b1, HEALTH_CONGESTED, 100, 1000);
        repeat (5) send_tick(0, 1'b1, HEALTH_OK, 100, 1000);
        send_tick(0, 1'b1, 2'd3, 100, 1000);
        send_tick(0, 1'b1, 2'd1, 100, 1000);
        send_tick(0, 1'b1, HEALTH_OK, 106, 1000);
        send_tick(0, 1'b1, HEALTH_OK, 111, 1000);
        send_tick(1, 1'b0, HEALTH_CONGESTED, 7, 500);
        send_tick(2, 1'b1, HEALTH_OK, 9, 0);
        send_tick(2, 1'b1, HEALTH_OK, 32'hFFFF_FFFF, 20'hF_FFFF);
        send_tick(2, 1'b1, HEALTH_OK, 32'h0000_0002, 20'hF_FFFF);
        send_tick(2, 1'b1, HEALTH_CONGESTED, 32'h0000_0002, 20'hF_FFFF);
        send_tick(7, 1'b1, HEALTH_OK, 0, 20'hF_FFFF);
        send_tick(7, 1'b0, 2'd3, 32'hFFFF_FFFF, 0);
        send_tick(5, 1'b1, HEALTH_CONGESTED, 40, 12345);
    endtask

    initial begin
        board = new();
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= CFG_DROP_LIMIT;
        cfg_data                <= '0;
        tick_bus.valid          <= 1'b0;
        tick_bus.session_index  <= '0;
        tick_bus.session_active <= 1'b0;
        tick_bus.health_code    <= HEALTH_OK;
        tick_bus.dropped_total  <= '0;
        tick_bus.profile_kbps   <= '0;
        for (int i = 0; i < NUM_SESSIONS; i++) begin
            gen_drops[i]   = $urandom;
            gen_profile[i] = random_profile();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_for_results();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // Register settings run from the reset values through both extremes
            // (zero cooldown acts as one; percentages above one hundred saturate)
            // to random mixtures.
            case (phase)
                0:       program_governor(5, 20, 40, 300, 5);
                1:       program_governor(0, 0, 0, 0, 0);
                2:       program_governor(16'hFFFF, 100, 0, 16'hFFFF, 1);
                3:       program_governor(3, 127, 127, 1000, 255);
                4:       program_governor(10, 50, 30, 5000, 2);
                5:       program_governor(1, 10, 90, 20, 3);
                default: program_governor(16'($urandom_range(40)), 16'($urandom_range(127)),
                                          16'($urandom_range(127)),
                                          16'($urandom_range(16'hFFFF)),
                                          16'($urandom_range(12)));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // In the first unthrottled phase the receiver holds off while the
            // sender keeps offering, so the input side must back up.
            if (phase == 0)
                hold_request = 1'b1;
            repeat (PHASE_WORDS) send_random_tick();
            wait_for_results();
        end

        if (board.failures == 0)
            $display("aimd_bitrate_governor: match");
        else
            $display("aimd_bitrate_governor: mismatch");
        $finish;
    end

endmodule
